### hw/rtl/pmt_pkg.sv
// shared types, constants and literal tables for the movetext tokenizer
package pmt_pkg;

  localparam int TOKEN_MAX_DEF = 16;
  localparam int DEPTH_MAX_DEF = 255;
  localparam int QUEUE_DEPTH   = 2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_COMMENT   = 2'd1;
  localparam logic [1:0] ST_VARIATION = 2'd2;
  localparam logic [1:0] ST_ESCAPE    = 2'd3;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // command from front to back, one per accepted beat at most
  typedef struct packed {
    logic       has_tok;
    logic       bank;
    logic       has_status;
    logic [1:0] status;
    logic       rs;
  } cmd_ctl_t;

  // result literals: 0 "1-0", 1 "0-1", 2 "1/2-1/2", 3 "*"
  function automatic logic [2:0] lit_len(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd0:    r = 3'd3;
      2'd1:    r = 3'd3;
      2'd2:    r = 3'd7;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] r;
    case ({k, pos})
      {2'd0, 3'd0}: r = CH_ONE;
      {2'd0, 3'd1}: r = CH_DASH;
      {2'd0, 3'd2}: r = CH_ZERO;
      {2'd1, 3'd0}: r = CH_ZERO;
      {2'd1, 3'd1}: r = CH_DASH;
      {2'd1, 3'd2}: r = CH_ONE;
      {2'd2, 3'd0}: r = CH_ONE;
      {2'd2, 3'd1}: r = CH_SLASH;
      {2'd2, 3'd2}: r = CH_TWO;
      {2'd2, 3'd3}: r = CH_DASH;
      {2'd2, 3'd4}: r = CH_ONE;
      {2'd2, 3'd5}: r = CH_SLASH;
      {2'd2, 3'd6}: r = CH_TWO;
      {2'd3, 3'd0}: r = CH_STAR;
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

  // prefix match flags after one more character at position pos
  function automatic logic [3:0] lit_next(input logic [3:0] m, input logic [2:0] pos,
                                          input logic [7:0] c);
    logic [3:0] r;
    for (int k = 0; k < 4; k++) begin
      r[k] = m[k] && (pos < lit_len(2'(k))) && (c == lit_char(2'(k), pos));
    end
    return r;
  endfunction

  // whole literal matched when the character at pos is its last one
  function automatic logic lit_full(input logic [3:0] m, input logic [2:0] pos);
    logic r;
    r = 1'b0;
    for (int k = 0; k < 4; k++) begin
      r = r | (m[k] && (pos == lit_len(2'(k)) - 3'd1));
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

### hw/rtl/pmt_queue.sv
// small command queue between the front and the back
module pmt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pmt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/pmt_front.sv
// front end: byte classification, nesting/comment tracking, token capture
module pmt_front #(
  parameter int TOKEN_MAX = pmt_pkg::TOKEN_MAX_DEF,
  parameter int DEPTH_MAX = pmt_pkg::DEPTH_MAX_DEF,
  localparam int LEN_W = $clog2(TOKEN_MAX + 1),
  localparam int IDX_W = $clog2(TOKEN_MAX)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  input  logic              q_full,
  output logic              q_push,
  output pmt_pkg::cmd_ctl_t q_ctl,
  output logic [LEN_W-1:0]  q_len,
  output logic              wr_en,
  output logic              wr_bank,
  output logic [IDX_W-1:0]  wr_idx,
  output logic [7:0]        wr_data,
  input  logic              release_bank
);

  localparam int DEP_W = $clog2(DEPTH_MAX + 1);

  // move-number recognizer codes
  localparam logic [1:0] NUM_START = 2'd0;
  localparam logic [1:0] NUM_DIG   = 2'd1;
  localparam logic [1:0] NUM_DOT   = 2'd2;
  localparam logic [1:0] NUM_BAD   = 2'd3;

  logic             comment_open, comment_open_next;
  logic [DEP_W-1:0] depth, depth_next;
  logic             line_start, line_start_next;
  logic             failed, failed_next;
  logic             result_flag, result_flag_next;
  logic [LEN_W-1:0] tok_len;
  logic [LEN_W-1:0] kept_len;
  logic [1:0]       num_st, num_st_next;
  logic             num_kept;
  logic [3:0]       lit_m, lit_m_next;
  logic             res_kept;
  logic             first_dollar;
  logic             wbank;
  logic [1:0]       busy;

  logic fire, nl, bang, is_digit, pos_ok;
  logic flushable, flush_emit, flush_res;
  logic do_flush, do_clear, do_store, do_reset;
  logic has_st;
  logic [1:0] st;

  assign in_ready = !q_full && (busy != 2'd2);
  assign fire     = in_valid && in_ready;
  assign nl       = (in_byte == pmt_pkg::CH_LF) || (in_byte == pmt_pkg::CH_CR);
  assign bang     = (in_byte == pmt_pkg::CH_BANG) || (in_byte == pmt_pkg::CH_QUEST);
  assign is_digit = (in_byte >= pmt_pkg::CH_ZERO) && (in_byte <= pmt_pkg::CH_NINE);
  assign pos_ok   = (tok_len < LEN_W'(7));

  // class of the pending token, known before it ends
  assign flushable  = (tok_len != '0) && (depth == '0) && (kept_len != '0) &&
                      !num_kept && !first_dollar;
  assign flush_emit = flushable && !res_kept;
  assign flush_res  = flushable && res_kept;

  always_comb begin
    num_st_next = num_st;
    unique case (num_st)
      NUM_START: num_st_next = is_digit ? NUM_DIG : NUM_BAD;
      NUM_DIG: begin
        if (is_digit) begin
          num_st_next = NUM_DIG;
        end else if (in_byte == pmt_pkg::CH_DOT) begin
          num_st_next = NUM_DOT;
        end else begin
          num_st_next = NUM_BAD;
        end
      end
      NUM_DOT: num_st_next = (in_byte == pmt_pkg::CH_DOT) ? NUM_DOT : NUM_BAD;
      default: num_st_next = NUM_BAD;
    endcase
    lit_m_next = pos_ok ? pmt_pkg::lit_next(lit_m, tok_len[2:0], in_byte) : 4'b0000;
  end

  always_comb begin
    comment_open_next = comment_open;
    depth_next        = depth;
    line_start_next   = line_start;
    failed_next       = failed;
    result_flag_next  = result_flag;
    do_flush = 1'b0;
    do_clear = 1'b0;
    do_store = 1'b0;
    do_reset = 1'b0;
    has_st   = 1'b0;
    st       = pmt_pkg::ST_OK;
    if (fire) begin
      if (in_end) begin
        do_reset = 1'b1;
        if (!failed) begin
          do_flush = 1'b1;
          has_st   = 1'b1;
          if (comment_open) begin
            st = pmt_pkg::ST_COMMENT;
          end else if (depth != '0) begin
            st = pmt_pkg::ST_VARIATION;
          end
        end
      end else if (!failed) begin
        if (line_start && in_byte == pmt_pkg::CH_PCT) begin
          do_clear    = 1'b1;
          failed_next = 1'b1;
          has_st      = 1'b1;
          st          = pmt_pkg::ST_ESCAPE;
        end else if (comment_open) begin
          if (in_byte == pmt_pkg::CH_RBRACE) begin
            comment_open_next = 1'b0;
          end
          line_start_next = nl;
        end else if (in_byte == pmt_pkg::CH_LBRACE) begin
          do_flush          = 1'b1;
          comment_open_next = 1'b1;
          line_start_next   = 1'b0;
        end else if (in_byte == pmt_pkg::CH_LPAREN) begin
          do_flush        = 1'b1;
          line_start_next = 1'b0;
          if (depth == DEP_W'(DEPTH_MAX)) begin
            failed_next = 1'b1;
            has_st      = 1'b1;
            st          = pmt_pkg::ST_VARIATION;
          end else begin
            depth_next = depth + DEP_W'(1);
          end
        end else if (in_byte == pmt_pkg::CH_RPAREN) begin
          do_flush        = 1'b1;
          line_start_next = 1'b0;
          if (depth == '0) begin
            failed_next = 1'b1;
            has_st      = 1'b1;
            st          = pmt_pkg::ST_VARIATION;
          end else begin
            depth_next = depth - DEP_W'(1);
          end
        end else if (pmt_pkg::is_space(in_byte)) begin
          do_flush        = 1'b1;
          line_start_next = nl;
        end else begin
          do_store        = (depth == '0) && (tok_len < LEN_W'(TOKEN_MAX));
          line_start_next = 1'b0;
        end
      end
    end
    if (do_flush && flush_res) begin
      result_flag_next = 1'b1;
    end
    if (do_reset) begin
      comment_open_next = 1'b0;
      depth_next        = '0;
      line_start_next   = 1'b1;
      failed_next       = 1'b0;
      result_flag_next  = 1'b0;
    end
  end

  always_comb begin
    q_ctl.has_tok    = do_flush && flush_emit;
    q_ctl.bank       = wbank;
    q_ctl.has_status = has_st;
    q_ctl.status     = st;
    q_ctl.rs         = do_flush ? (result_flag | flush_res) : result_flag;
    q_push           = q_ctl.has_tok || has_st;
    q_len            = kept_len;
  end

  assign wr_en   = do_store;
  assign wr_bank = wbank;
  assign wr_idx  = tok_len[IDX_W-1:0];
  assign wr_data = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_open <= 1'b0;
      depth        <= '0;
      line_start   <= 1'b1;
      failed       <= 1'b0;
      result_flag  <= 1'b0;
      wbank        <= 1'b0;
      busy         <= 2'd0;
    end else begin
      comment_open <= comment_open_next;
      depth        <= depth_next;
      line_start   <= line_start_next;
      failed       <= failed_next;
      result_flag  <= result_flag_next;
      if (q_ctl.has_tok) begin
        wbank <= !wbank;
      end
      busy <= busy + {1'b0, q_ctl.has_tok} - {1'b0, release_bank};
    end
  end

  // token capture and running classification
  always_ff @(posedge clk) begin
    if (rst || do_flush || do_clear || do_reset) begin
      tok_len      <= '0;
      kept_len     <= '0;
      num_st       <= NUM_START;
      num_kept     <= 1'b0;
      lit_m        <= 4'b1111;
      res_kept     <= 1'b0;
      first_dollar <= 1'b0;
    end else if (do_store) begin
      tok_len <= tok_len + LEN_W'(1);
      num_st  <= num_st_next;
      lit_m   <= lit_m_next;
      if (tok_len == '0) begin
        first_dollar <= (in_byte == pmt_pkg::CH_DOLLAR);
      end
      if (!bang) begin
        kept_len <= tok_len + LEN_W'(1);
        num_kept <= (num_st_next == NUM_DIG) || (num_st_next == NUM_DOT);
        res_kept <= pmt_pkg::lit_full(lit_m_next, tok_len[2:0]);
      end
    end
  end

  a_no_accept_when_banks_taken: assert property (@(posedge clk) disable iff (rst)
    fire |-> busy != 2'd2)
    else $error("byte accepted while both token banks are owned by the back");

  a_bank_owned_after_emit: assert property (@(posedge clk) disable iff (rst)
    (fire && q_ctl.has_tok) |=> busy != 2'd0)
    else $error("emitted token lost its bank ownership");

endmodule

### hw/rtl/pmt_back.sv
// back end: token bank memory and serial emission of characters and status
module pmt_back #(
  parameter int TOKEN_MAX = pmt_pkg::TOKEN_MAX_DEF,
  localparam int LEN_W = $clog2(TOKEN_MAX + 1),
  localparam int IDX_W = $clog2(TOKEN_MAX)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  pmt_pkg::cmd_ctl_t q_ctl,
  input  logic [LEN_W-1:0]  q_len,
  input  logic              wr_en,
  input  logic              wr_bank,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [7:0]        wr_data,
  output logic              release_bank,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_last,
  output logic              out_is_status,
  output logic [1:0]        out_status,
  output logic              out_rs
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TOK  = 2'd1;
  localparam logic [1:0] S_STAT = 2'd2;

  logic [7:0]        tok_mem [2][TOKEN_MAX];
  logic [1:0]        state;
  pmt_pkg::cmd_ctl_t cur_ctl;
  logic [LEN_W-1:0]  cur_len;
  logic [IDX_W-1:0]  idx;
  logic              out_free, emit_tok, emit_st, tok_end;

  assign out_free     = !out_valid || out_ready;
  assign emit_tok     = (state == S_TOK) && out_free;
  assign emit_st      = (state == S_STAT) && out_free;
  assign tok_end      = (LEN_W'(idx) + LEN_W'(1)) == cur_len;
  assign release_bank = emit_tok && tok_end;
  assign q_pop        = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tok_mem[wr_bank][wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit_tok || emit_st) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            idx   <= '0;
            state <= q_ctl.has_tok ? S_TOK : S_STAT;
          end
        end
        S_TOK: begin
          if (emit_tok) begin
            idx <= idx + IDX_W'(1);
            if (tok_end) begin
              state <= cur_ctl.has_status ? S_STAT : S_IDLE;
            end
          end
        end
        S_STAT: begin
          if (emit_st) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // registered memory read lands straight in the output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_ctl <= q_ctl;
      cur_len <= q_len;
    end
    if (emit_tok) begin
      out_char      <= tok_mem[cur_ctl.bank][idx];
      out_last      <= tok_end;
      out_is_status <= 1'b0;
      out_status    <= pmt_pkg::ST_OK;
      out_rs        <= cur_ctl.rs;
    end else if (emit_st) begin
      out_char      <= 8'h00;
      out_last      <= 1'b0;
      out_is_status <= 1'b1;
      out_status    <= cur_ctl.status;
      out_rs        <= cur_ctl.rs;
    end
  end

  a_status_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_is_status) |-> (!out_last && out_char == 8'h00))
    else $error("status beat carries character fields");

  a_token_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOK) |-> cur_len != '0)
    else $error("empty token reached the emitter");

endmodule

### hw/rtl/pgn_movetext_tokenizer.sv
// top level of the chess movetext tokenizer
// flush path: the beat that ends a token queues a command, the back pops it and reads the
//   token bank into the output register; a status beat follows the token's last character
// throughput: one input beat per cycle while the command queue has room and a token bank
//   is free; the back pops a command when idle, then emits one result per cycle while its
//   output register is free
// reset: rst is synchronous; it clears all control state, the token banks are not cleared
module pgn_movetext_tokenizer #(
  parameter int TOKEN_MAX = pmt_pkg::TOKEN_MAX_DEF,
  parameter int DEPTH_MAX = pmt_pkg::DEPTH_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel: one movetext character per beat
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  // result channel: token characters and final status
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_char, [9:8] status, [10] result_seen
  output logic        m_axis_tlast,   // token_last
  output logic [0:0]  m_axis_tuser    // [0] is_status
);

  localparam int LEN_W = $clog2(TOKEN_MAX + 1);
  localparam int IDX_W = $clog2(TOKEN_MAX);
  localparam int CTL_W = $bits(pmt_pkg::cmd_ctl_t);
  localparam int CMD_W = CTL_W + LEN_W;

  // front to queue
  logic              q_push;
  logic              q_full;
  pmt_pkg::cmd_ctl_t f_ctl;
  logic [LEN_W-1:0]  f_len;

  // queue to back
  logic              q_valid;
  logic              q_pop;
  logic [CMD_W-1:0]  q_dout;
  pmt_pkg::cmd_ctl_t b_ctl;
  logic [LEN_W-1:0]  b_len;

  // token bank write port, front owns the bank it is filling
  logic              wr_en;
  logic              wr_bank;
  logic [IDX_W-1:0]  wr_idx;
  logic [7:0]        wr_data;
  // back returns a bank once its last character has been read
  logic              release_bank;

  // output register fields
  logic [7:0]        out_char;
  logic              out_last;
  logic              out_is_status;
  logic [1:0]        out_status;
  logic              out_rs;

  pmt_front #(
    .TOKEN_MAX(TOKEN_MAX),
    .DEPTH_MAX(DEPTH_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .in_end      (s_axis_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ctl       (f_ctl),
    .q_len       (f_len),
    .wr_en       (wr_en),
    .wr_bank     (wr_bank),
    .wr_idx      (wr_idx),
    .wr_data     (wr_data),
    .release_bank(release_bank)
  );

  // commands carry token length above the control bits
  pmt_queue #(
    .WIDTH(CMD_W),
    .DEPTH(pmt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({f_len, f_ctl}),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_data (q_dout)
  );

  assign b_ctl = pmt_pkg::cmd_ctl_t'(q_dout[CTL_W-1:0]);
  assign b_len = q_dout[CMD_W-1:CTL_W];

  pmt_back #(
    .TOKEN_MAX(TOKEN_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_ctl        (b_ctl),
    .q_len        (b_len),
    .wr_en        (wr_en),
    .wr_bank      (wr_bank),
    .wr_idx       (wr_idx),
    .wr_data      (wr_data),
    .release_bank (release_bank),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_is_status(out_is_status),
    .out_status   (out_status),
    .out_rs       (out_rs)
  );

  assign m_axis_tdata = {5'b00000, out_rs, out_status, out_char};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_is_status;

endmodule

### sim/testbench.sv
// self-checking testbench for the movetext tokenizer: directed cases, random games, stalls
`timescale 1ns / 100ps

module testbench;

  localparam int TOKEN_MAX  = pmt_pkg::TOKEN_MAX_DEF;
  // small nesting limit keeps the limit case short
  localparam int DEPTH_MAX  = 4;
  localparam int ITEM_TARGET = 220;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS = 5_000_000;

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  // one result beat as the block should present it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       is_st;
    logic [1:0] st;
    logic       rseen;
  } tok_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] text_byte
  logic        s_axis_tlast = 1'b0;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [7:0] out_char, [9:8] status, [10] result_seen
  logic        m_axis_tlast;          // token_last
  logic [0:0]  m_axis_tuser;          // [0] is_status

  pgn_movetext_tokenizer #(
    .TOKEN_MAX(TOKEN_MAX),
    .DEPTH_MAX(DEPTH_MAX)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tokenizer state as the testbench tracks it
  logic        brace_open;
  int unsigned var_depth;
  logic        line_head;
  logic [7:0]  tok_buf [TOKEN_MAX];
  int          tok_len;
  int          kept_len;
  logic        result_mark;
  logic        halted;

  tok_result_t tok_results_due[$];
  int          mismatches = 0;
  int          sent_beats = 0;

  function automatic void clear_parser();
    brace_open  = 1'b0;
    var_depth   = 0;
    line_head   = 1'b1;
    tok_len     = 0;
    kept_len    = 0;
    result_mark = 1'b0;
    halted      = 1'b0;
  endfunction

  function automatic void expect_result(logic [7:0] ch, logic last, logic is_st,
                                        logic [1:0] st);
    tok_result_t r;
    r.ch    = ch;
    r.last  = last;
    r.is_st = is_st;
    r.st    = st;
    r.rseen = result_mark;
    tok_results_due.insert(tok_results_due.size(), r);
  endfunction

  function automatic void fail_with(logic [1:0] st);
    halted = 1'b1;
    expect_result(8'h00, 1'b0, 1'b1, st);
  endfunction

  function automatic logic token_is(string lit);
    if (lit.len() != kept_len) return 1'b0;
    for (int i = 0; i < kept_len; i++) begin
      if (tok_buf[i] != lit[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // digits, then nothing but dots
  function automatic logic token_is_move_number();
    int i;
    i = 0;
    while (i < kept_len && tok_buf[i] >= pmt_pkg::CH_ZERO && tok_buf[i] <= pmt_pkg::CH_NINE)
      i++;
    if (i == 0) return 1'b0;
    while (i < kept_len && tok_buf[i] == pmt_pkg::CH_DOT) i++;
    return i == kept_len;
  endfunction

  function automatic void end_token();
    if (tok_len == 0 || var_depth > 0) begin
      tok_len = 0;
      return;
    end
    kept_len = tok_len;
    tok_len  = 0;
    while (kept_len > 0 && (tok_buf[kept_len-1] == pmt_pkg::CH_BANG ||
                            tok_buf[kept_len-1] == pmt_pkg::CH_QUEST))
      kept_len--;
    if (kept_len == 0 || token_is_move_number() || tok_buf[0] == pmt_pkg::CH_DOLLAR) return;
    if (token_is("1-0") || token_is("0-1") || token_is("1/2-1/2") || token_is("*")) begin
      result_mark = 1'b1;
      return;
    end
    for (int i = 0; i < kept_len; i++)
      expect_result(tok_buf[i], i == kept_len - 1, 1'b0, pmt_pkg::ST_OK);
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic eot);
    logic nl;
    if (eot) begin
      if (!halted) begin
        end_token();
        expect_result(8'h00, 1'b0, 1'b1,
                      brace_open ? pmt_pkg::ST_COMMENT :
                      (var_depth != 0 ? pmt_pkg::ST_VARIATION : pmt_pkg::ST_OK));
      end
      clear_parser();
      return;
    end
    if (halted) return;
    nl = (c == pmt_pkg::CH_LF || c == pmt_pkg::CH_CR);
    if (line_head && c == pmt_pkg::CH_PCT) begin
      tok_len = 0;
      fail_with(pmt_pkg::ST_ESCAPE);
      return;
    end
    if (brace_open) begin
      if (c == pmt_pkg::CH_RBRACE) brace_open = 1'b0;
      line_head = nl;
      return;
    end
    if (c == pmt_pkg::CH_LBRACE) begin
      end_token();
      brace_open = 1'b1;
      line_head  = 1'b0;
    end else if (c == pmt_pkg::CH_LPAREN) begin
      end_token();
      if (var_depth >= DEPTH_MAX) begin
        fail_with(pmt_pkg::ST_VARIATION);
        return;
      end
      var_depth++;
      line_head = 1'b0;
    end else if (c == pmt_pkg::CH_RPAREN) begin
      end_token();
      if (var_depth == 0) begin
        fail_with(pmt_pkg::ST_VARIATION);
        return;
      end
      var_depth--;
      line_head = 1'b0;
    end else if (c == pmt_pkg::CH_SPACE || (c >= pmt_pkg::CH_TAB && c <= pmt_pkg::CH_CR)) begin
      end_token();
      line_head = nl;
    end else begin
      if (var_depth == 0 && tok_len < TOKEN_MAX) begin
        tok_buf[tok_len] = c;
        tok_len++;
      end
      line_head = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin
    tok_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (tok_results_due.size() == 0) begin
        $error("unexpected result beat: tdata %h tlast %b tuser %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatches++;
      end else begin
        want = tok_results_due.pop_front();
        if (m_axis_tdata[7:0] !== want.ch) begin
          $error("out_char: expected %h, actual %h", want.ch, m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("token_last: expected %b, actual %b", want.last, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.is_st) begin
          $error("is_status: expected %b, actual %b", want.is_st, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata[9:8] !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, m_axis_tdata[9:8]);
          mismatches++;
        end
        if (m_axis_tdata[10] !== want.rseen) begin
          $error("result_seen: expected %b, actual %b", want.rseen, m_axis_tdata[10]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: switches between random stall habits, and serves long hold requests
  int holds_asked  = 0;
  int holds_served = 0;

  initial begin
    int rx_cycle;
    int rx_mode;
    int hold_left;
    rx_cycle  = 0;
    rx_mode   = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
          2:       m_axis_tready <= (rx_cycle % 3 != 0);
          default: m_axis_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps between them
  logic        gaps_on = 1'b1;
  int          burst_left = 0;
  logic [7:0]  text_q[$];

  function automatic void put_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic eot);
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_beats++;
    tokenize_byte(b, eot);
    if (gaps_on) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // sends the queued text, then the end marker with a random byte beside it
  task automatic send_game();
    foreach (text_q[i]) send_beat(text_q[i], 1'b0);
    text_q.delete();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic void add_ws();
    case ($urandom_range(0, 11))
      0:       put_byte(pmt_pkg::CH_TAB);
      1:       put_byte(pmt_pkg::CH_LF);
      2:       put_byte(CH_VT);
      3:       put_byte(CH_FF);
      4:       put_byte(pmt_pkg::CH_CR);
      5:       begin put_byte(pmt_pkg::CH_CR); put_byte(pmt_pkg::CH_LF); end
      default: put_byte(pmt_pkg::CH_SPACE);
    endcase
  endfunction

  function automatic void add_move();
    string files;
    string pieces;
    int    kind;
    files  = "abcdefgh";
    pieces = "NBRQK";
    kind   = $urandom_range(0, 19);
    if (kind == 0) begin
      add_str($urandom_range(0, 1) ? "O-O" : "O-O-O");
    end else if (kind == 1) begin
      // runs past the token store
      repeat ($urandom_range(TOKEN_MAX + 1, TOKEN_MAX + 6))
        put_byte(files[$urandom_range(0, 7)]);
    end else begin
      if (kind > 12) put_byte(pieces[$urandom_range(0, 4)]);
      if (kind % 4 == 0) begin
        put_byte(files[$urandom_range(0, 7)]);
        add_str("x");
      end
      put_byte(files[$urandom_range(0, 7)]);
      put_byte(pmt_pkg::CH_ONE + 8'($urandom_range(0, 7)));
      case (kind)
        2:       put_byte(8'($urandom_range(128, 255)));
        3:       add_str("=Q");
        5:       add_str("+");
        6:       add_str("#");
        7:       add_str("!");
        9:       add_str("?!");
        10:      add_str("!!");
        default: ;
      endcase
    end
  endfunction

  function automatic void add_comment();
    add_str("{");
    case ($urandom_range(0, 5))
      0:       add_str("better (was Nf3)");
      1:       begin add_str("line"); put_byte(pmt_pkg::CH_LF); add_str("next"); end
      2:       begin add_str("bad"); put_byte(pmt_pkg::CH_CR); add_str("%"); end
      default: add_str(" only move ");
    endcase
    add_str("}");
    add_ws();
  endfunction

  function automatic void add_variation(int m);
    add_str($sformatf("(%0d... ", m));
    add_move();
    add_ws();
    if ($urandom_range(0, 2) == 0) begin
      add_str("(");
      add_move();
      add_str(")");
      add_ws();
    end
    add_move();
    add_str(")");
    add_ws();
  endfunction

  function automatic void add_game();
    int moves;
    moves = $urandom_range(1, 6);
    if ($urandom_range(0, 19) == 0) begin
      add_str("%comment line");
      put_byte(pmt_pkg::CH_LF);
    end
    for (int m = 1; m <= moves; m++) begin
      add_str($sformatf("%0d.", m));
      if ($urandom_range(0, 5) != 0) add_ws();
      add_move();
      add_ws();
      if ($urandom_range(0, 6) == 0) add_comment();
      if ($urandom_range(0, 6) == 0) add_variation(m);
      if ($urandom_range(0, 8) == 0) begin
        add_str($sformatf("$%0d", $urandom_range(0, 255)));
        add_ws();
      end
      add_move();
      add_ws();
    end
    case ($urandom_range(0, 11))
      0:       add_str("1-0");
      1:       add_str("0-1");
      2:       add_str("1/2-1/2");
      3:       add_str("*");
      4:       add_str("e4)");
      5:       begin add_str("("); add_move(); end
      6:       add_str("{open");
      default: ;
    endcase
  endfunction

  // raw bytes, biased toward the characters that steer the parser
  function automatic void add_noise();
    string marks;
    marks = "%{}()$!?. 0123456789/-*";
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 2) == 0)
        put_byte(8'($urandom_range(0, 255)));
      else if ($urandom_range(0, 3) == 0)
        put_byte(pmt_pkg::CH_LF);
      else
        put_byte(marks[$urandom_range(0, marks.len() - 1)]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // directed tests

  // trimming, move numbers, annotations, all four result tokens
  task automatic test_token_classes();
    add_str("1. e4! e5?? 2... Nf3!? $14 !? 1/2-1/2 0-1 1-0 * 1-00");
    send_game();
  endtask

  // each separator other than the space, and bytes with the top bit set inside a token
  task automatic test_separators();
    add_str("a");
    put_byte(pmt_pkg::CH_TAB);
    add_str("b");
    put_byte(CH_VT);
    put_byte(8'h80);
    put_byte(CH_FF);
    put_byte(8'hFF);
    put_byte(pmt_pkg::CH_CR);
    put_byte(8'h7F);
    put_byte(pmt_pkg::CH_LF);
    put_byte(8'h00);
    send_game();
  endtask

  // store overflow: extra characters dropped, trailing marks beyond the store not trimmed
  task automatic test_long_token();
    add_str("abcdefghijklmnopqrst ABCDEFGHIJKLMNOP!!");
    send_game();
  endtask

  // end status with comment open, variation open, and clean
  task automatic test_open_at_end();
    add_str("e4 {c (x)} (d4 {y} (c5) Nf3) Bc4 {");
    send_game();
    add_str("(e4");
    send_game();
    add_str("Qh5");
    send_game();
  endtask

  // escape line at start, after LF, after CR inside a comment, and '%' mid-line
  task automatic test_escape_line();
    add_str("%x e4");
    send_game();
    add_str("e4");
    put_byte(pmt_pkg::CH_LF);
    add_str("%");
    send_game();
    add_str("{a");
    put_byte(pmt_pkg::CH_CR);
    add_str("%} e5");
    send_game();
    add_str("e4 %x");
    send_game();
  endtask

  // close paren at top level flushes, then fails; later bytes ignored
  task automatic test_unmatched_close();
    add_str("e4) f5 (");
    send_game();
  endtask

  // one open paren too many
  task automatic test_nesting_limit();
    repeat (DEPTH_MAX) put_byte(pmt_pkg::CH_LPAREN);
    add_str("x(");
    send_game();
  endtask

  // receiver holds off while moves keep coming, so the input side backs up
  task automatic test_output_hold();
    gaps_on = 1'b0;
    holds_asked++;
    repeat (3) begin
      add_move();
      add_ws();
    end
    add_str("Nf3 Nc6 Bb5");
    send_game();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_games();
    do begin
      // stretches without sender gaps now and then
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) add_noise();
      else add_game();
      send_game();
    end while (sent_beats < ITEM_TARGET);
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_token_classes();
    test_separators();
    test_long_token();
    test_open_at_end();
    test_escape_line();
    test_unmatched_close();
    test_nesting_limit();
    test_output_hold();
    test_random_games();

    s_axis_tvalid <= 1'b0;
    while (tok_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && tok_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
